// ===== rtl/lmrs_pkg.sv =====
// shared types, constants and word builder for the led matrix row scanner
package lmrs_pkg;

    // scan geometry and store sizes
    localparam int ROWS       = 16;
    localparam int STORE_ROWS = 16;
    localparam int ROW_W      = $clog2(STORE_ROWS);
    localparam int WORD_BITS  = 32;
    localparam int BIT_W      = $clog2(WORD_BITS);
    localparam int COLOR_W    = 8;
    localparam int HALF_W     = 16;

    // pwm blanking counter
    localparam int PWM_TOP    = 255;
    localparam int PWM_W      = $clog2(PWM_TOP + 1);
    localparam int BLANK_W    = 8;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_BIT_PERIOD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLANK_CMP  = 1'd1;

    localparam logic [HALF_W-1:0]  BIT_PERIOD_RESET = 16'd399;
    localparam logic [BLANK_W-1:0] BLANK_CMP_RESET  = 8'd100;

    // pixel store reset contents
    localparam logic [COLOR_W-1:0] RED_RESET   = 8'd219;
    localparam logic [COLOR_W-1:0] GREEN_RESET = 8'd109;

    // item operations
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    typedef enum logic [1:0] {
        PH_FIRST  = 2'd0,
        PH_SECOND = 2'd1,
        PH_LATCH  = 2'd2
    } t_phase;

    typedef struct packed {
        logic                op;
        logic [ROW_W-1:0]    row_index;
        logic [COLOR_W-1:0]  red_value;
        logic [COLOR_W-1:0]  green_value;
    } t_item;

    typedef struct packed {
        logic shift_clock;
        logic latch_clock;
        logic enable_n;
    } t_res;

    // inverted red/green interleave in the low half, one-hot row above it
    function automatic logic [WORD_BITS-1:0] make_word(
        input logic [ROW_W-1:0]   row,
        input logic [COLOR_W-1:0] r,
        input logic [COLOR_W-1:0] g
    );
        logic [HALF_W-1:0]    x;
        logic [WORD_BITS-1:0] sel;
        x = {g[7], r[7], g[6], r[6], g[5], r[5], g[4], r[4],
             r[0], g[0], r[1], g[1], r[2], g[2], r[3], g[3]};
        sel = {{(WORD_BITS-1){1'b0}}, 1'b1} << (32'(row) + HALF_W);
        return sel | {{(WORD_BITS-HALF_W){1'b0}}, ~x};
    endfunction

endpackage

// ===== rtl/lmrs_item_if.sv =====
// input item channel: valid, ready and one pixel-write or tick beat
interface lmrs_item_if;
    import lmrs_pkg::*;

    logic  valid;
    logic  ready;
    t_item item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

// ===== rtl/lmrs_res_if.sv =====
// result channel: valid, ready and the output line levels
interface lmrs_res_if;
    import lmrs_pkg::*;

    logic valid;
    logic ready;
    t_res res;

    modport source (output valid, output res, input ready);
    modport sink   (input valid, input res, output ready);
endinterface

// ===== rtl/led_matrix_row_scanner.sv =====
// led matrix row scanner: pixel store, scan sequencer and pwm blanking
// latency: a result beat is presented the cycle after its input beat is taken
// throughput: one item per cycle while the result register is empty or being drained; it refills while being drained
// the pixel store is a 16-entry memory with one write and one registered read port
// reset: synchronous, active low; per-row valid flags make unwritten rows read as
// red 219 / green 109 at once, so no clearing pass is needed after reset
module led_matrix_row_scanner (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [lmrs_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [lmrs_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    lmrs_item_if.sink                         i_item,
    lmrs_res_if.source                        o_res
);
    import lmrs_pkg::*;

    // configuration registers
    logic [HALF_W-1:0]  r_bit_period;
    logic [BLANK_W-1:0] r_blank_cmp;

    // pixel store: {red, green} per row, valid flag per row
    logic [2*COLOR_W-1:0] mem_pix [STORE_ROWS];
    logic [STORE_ROWS-1:0] r_row_valid;

    // snapshot of the row being scanned (registered memory read)
    logic [2*COLOR_W-1:0] r_snap_data;
    logic                 r_snap_valid;

    // scan state
    t_phase            r_phase, n_phase;
    logic [HALF_W-1:0] r_tick, n_tick;
    logic [BIT_W-1:0]  r_bit_pos, n_bit_pos;
    logic [ROW_W-1:0]  r_scan_row, n_scan_row;
    logic [PWM_W-1:0]  r_pwm, n_pwm;
    logic              row_load;

    // output register
    logic r_out_valid;
    t_res r_out;
    t_res n_res;

    logic                 acc;
    logic                 is_tick;
    logic                 is_write;
    logic [COLOR_W-1:0]   snap_red;
    logic [COLOR_W-1:0]   snap_green;
    logic [WORD_BITS-1:0] row_word;

    // input is taken whenever the result register is empty or being drained
    assign i_item.ready = !r_out_valid || o_res.ready;
    assign acc      = i_item.valid && i_item.ready;
    assign is_tick  = acc && (i_item.item.op == OP_TICK);
    assign is_write = acc && (i_item.item.op == OP_WRITE);

    assign o_res.valid = r_out_valid;
    assign o_res.res   = r_out;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_period <= BIT_PERIOD_RESET;
            r_blank_cmp  <= BLANK_CMP_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_BIT_PERIOD: r_bit_period <= i_cfg_data[HALF_W-1:0];
                CFG_BLANK_CMP:  r_blank_cmp  <= i_cfg_data[BLANK_W-1:0];
                default: ;
            endcase
        end
    end

    // pixel memory write port
    always_ff @(posedge i_clk) begin
        if (is_write) begin
            mem_pix[i_item.item.row_index] <= {i_item.item.red_value, i_item.item.green_value};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_valid <= '0;
        end else if (is_write) begin
            r_row_valid[i_item.item.row_index] <= 1'b1;
        end
    end

    // pixel memory read port: fetched on the tick that moves to the next row,
    // never in the same cycle as a write since one item is either kind
    always_ff @(posedge i_clk) begin
        if (row_load) begin
            r_snap_data <= mem_pix[n_scan_row];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snap_valid <= 1'b0;
        end else if (row_load) begin
            r_snap_valid <= r_row_valid[n_scan_row];
        end
    end

    assign snap_red   = r_snap_valid ? r_snap_data[2*COLOR_W-1:COLOR_W] : RED_RESET;
    assign snap_green = r_snap_valid ? r_snap_data[COLOR_W-1:0] : GREEN_RESET;
    assign row_word   = make_word(r_scan_row, snap_red, snap_green);

    // scan sequencer next state
    always_comb begin
        n_phase    = r_phase;
        n_tick     = r_tick;
        n_bit_pos  = r_bit_pos;
        n_scan_row = r_scan_row;
        n_pwm      = r_pwm;
        row_load   = 1'b0;
        if (is_tick) begin
            n_pwm = (32'(r_pwm) >= PWM_TOP) ? '0 : r_pwm + 1'b1;
            if (r_tick >= r_bit_period) begin
                n_tick = '0;
                unique case (r_phase)
                    PH_FIRST: begin
                        n_phase = PH_SECOND;
                    end
                    PH_SECOND: begin
                        if (32'(r_bit_pos) >= WORD_BITS - 1) begin
                            n_bit_pos = '0;
                            n_phase   = PH_LATCH;
                        end else begin
                            n_bit_pos = r_bit_pos + 1'b1;
                            n_phase   = PH_FIRST;
                        end
                    end
                    default: begin
                        // latch period ends: next row and a fresh snapshot
                        n_phase    = PH_FIRST;
                        n_bit_pos  = '0;
                        n_scan_row = (32'(r_scan_row) >= ROWS - 1) ? '0 : r_scan_row + 1'b1;
                        row_load   = 1'b1;
                    end
                endcase
            end else begin
                n_tick = r_tick + 1'b1;
            end
        end
    end

    // line levels from the state before this item
    always_comb begin
        n_res.shift_clock = 1'b1;
        n_res.latch_clock = 1'b1;
        unique case (r_phase)
            PH_FIRST: ;
            PH_SECOND: begin
                n_res.shift_clock = (r_tick == '0) ? 1'b0 : row_word[r_bit_pos];
            end
            default: begin
                n_res.latch_clock = (r_tick != '0);
            end
        endcase
        n_res.enable_n = (32'(r_pwm) < 32'(r_blank_cmp));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_FIRST;
            r_tick     <= '0;
            r_bit_pos  <= '0;
            r_scan_row <= '0;
            r_pwm      <= '0;
        end else begin
            r_phase    <= n_phase;
            r_tick     <= n_tick;
            r_bit_pos  <= n_bit_pos;
            r_scan_row <= n_scan_row;
            r_pwm      <= n_pwm;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_out_valid <= acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_out <= n_res;
        end
    end

    // a taken beat always leaves a result waiting in the next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc |=> r_out_valid)
        else $error("accepted beat produced no result");

    // latch pulse and shift clock low never overlap
    a_latch_shift_apart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.latch_clock |-> r_out.shift_clock)
        else $error("latch and shift clock both low");

    // bit counter is parked at zero through the latch period
    a_latch_bit_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_LATCH |-> r_bit_pos == '0)
        else $error("bit position moved during latch period");

    // a row snapshot is only taken at the start of a row
    a_row_load_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        row_load |=> r_phase == PH_FIRST && r_tick == '0 && r_bit_pos == '0)
        else $error("snapshot outside row start");

    // write beats leave the scan state alone
    a_write_holds_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        is_write |=> $stable(r_tick) && $stable(r_phase) && $stable(r_pwm))
        else $error("write beat advanced the scan");

endmodule
